>>> rtl/core/kes_pkg.sv
// ----------------------------------------------------------------------------
// kes_pkg
// Shared constants, event codes and the per-scan event plan of the keypad
// event scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package kes_pkg;

  localparam int ROW_COUNT      = 4;
  localparam int COLUMN_COUNT   = 5;
  localparam int POS_COUNT      = ROW_COUNT * COLUMN_COUNT;
  localparam int DEBOUNCE_LEVEL = 3;
  localparam int CNT_W          = $clog2(DEBOUNCE_LEVEL + 1);
  localparam int POS_W          = 5;
  localparam int TIME_W         = 32;
  localparam int MS_W           = 16;
  localparam int MAX_RESULTS    = 21;
  localparam int EVCNT_W        = $clog2(MAX_RESULTS);

  // Reset values of the timing and mask registers
  localparam logic [MS_W-1:0]      LONG_PRESS_RESET     = 16'd1000;
  localparam logic [MS_W-1:0]      REPEAT_INITIAL_RESET = 16'd500;
  localparam logic [MS_W-1:0]      REPEAT_PERIOD_RESET  = 16'd100;
  localparam logic [POS_COUNT-1:0] KEY_MASK_RESET       = 20'd1031663;

  typedef enum logic [2:0] {
    EV_PRESS   = 3'd0,
    EV_SHORT   = 3'd1,
    EV_LONG    = 3'd2,
    EV_REPEAT  = 3'd3,
    EV_RELEASE = 3'd4
  } event_kind_t;

  typedef enum logic [1:0] {
    REG_LONG_PRESS     = 2'd0,
    REG_REPEAT_INITIAL = 2'd1,
    REG_REPEAT_PERIOD  = 2'd2,
    REG_KEY_MASK       = 2'd3
  } cfg_reg_t;

  // Everything one scan emits, in emission order:
  // SHORT, RELEASE, PRESS per set bit (ascending), LONG, REPEAT.
  typedef struct packed {
    logic                  short_ev;
    logic                  release_ev;
    logic [POS_W-1:0]      release_pos;
    logic [TIME_W-1:0]     release_dur;
    logic [POS_COUNT-1:0]  press_mask;
    logic                  long_ev;
    logic                  repeat_ev;
    logic [POS_W-1:0]      held_pos;
    logic [TIME_W-1:0]     held_dur;
  } kes_plan_t;

endpackage

`default_nettype wire

>>> rtl/core/kes_lane.sv
// ----------------------------------------------------------------------------
// kes_lane
// Debounce lane for one matrix position: saturating up/down counter and
// edge detection against the debounce threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module kes_lane (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic scan_en,
  input  wire logic sample,
  output logic      pressed,
  output logic      rise,
  output logic      fall
);

  logic [kes_pkg::CNT_W-1:0] cnt_r;
  logic [kes_pkg::CNT_W-1:0] cnt_nxt;
  logic                      was;

  always_comb begin
    cnt_nxt = cnt_r;
    if (sample) begin
      if (cnt_r < kes_pkg::CNT_W'(kes_pkg::DEBOUNCE_LEVEL)) begin
        cnt_nxt = cnt_r + kes_pkg::CNT_W'(1);
      end
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - kes_pkg::CNT_W'(1);
    end
  end

  assign was     = (cnt_r >= kes_pkg::CNT_W'(kes_pkg::DEBOUNCE_LEVEL));
  assign pressed = (cnt_nxt >= kes_pkg::CNT_W'(kes_pkg::DEBOUNCE_LEVEL));
  assign rise    = pressed & ~was;
  assign fall    = ~pressed & was;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (scan_en) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/kes_merge.sv
// ----------------------------------------------------------------------------
// kes_merge
// Combines the edges found by the lanes with the held-key state: decides the
// release, the presses and the long/repeat timing of one scan.
// ----------------------------------------------------------------------------
`default_nettype none

module kes_merge (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            fire,
  input  wire logic [kes_pkg::POS_COUNT-1:0]   rise_mask,
  input  wire logic [kes_pkg::POS_COUNT-1:0]   fall_mask,
  input  wire logic [kes_pkg::POS_COUNT-1:0]   present_mask,
  input  wire logic [kes_pkg::TIME_W-1:0]      now_ms,
  input  wire logic [kes_pkg::MS_W-1:0]        long_hold_ms,
  input  wire logic [kes_pkg::MS_W-1:0]        first_repeat_ms,
  input  wire logic [kes_pkg::MS_W-1:0]        repeat_period_ms,
  output kes_pkg::kes_plan_t                   plan
);

  logic                           held_valid_r;
  logic [kes_pkg::POS_W-1:0]      held_pos_r;
  logic [kes_pkg::TIME_W-1:0]     press_time_r;
  logic                           long_sent_r;
  logic                           repeat_sent_r;
  logic [kes_pkg::TIME_W-1:0]     last_repeat_r;

  logic [kes_pkg::POS_COUNT-1:0]  press_m;
  logic [kes_pkg::POS_COUNT-1:0]  below_m;
  logic                           any_press;
  logic [kes_pkg::POS_W-1:0]      hi_pos;
  logic                           rel;
  logic                           held_valid_b;
  logic [kes_pkg::POS_W-1:0]      held_pos_b;
  logic [kes_pkg::TIME_W-1:0]     press_time_b;
  logic                           long_sent_b;
  logic                           repeat_sent_b;
  logic [kes_pkg::TIME_W-1:0]     held_dur;
  logic                           long_fire;
  logic                           long_sent_c;
  logic [kes_pkg::TIME_W-1:0]     stamp_c;
  logic [kes_pkg::MS_W-1:0]       delay;
  logic [kes_pkg::TIME_W-1:0]     since_rep;
  logic                           rep_fire;

  assign press_m   = rise_mask & present_mask;
  assign any_press = |press_m;
  assign below_m   = (kes_pkg::POS_COUNT'(1) << held_pos_r) - kes_pkg::POS_COUNT'(1);

  // Highest press wins the held slot
  always_comb begin
    hi_pos = '0;
    for (int p = 0; p < kes_pkg::POS_COUNT; p++) begin
      if (press_m[p]) begin
        hi_pos = kes_pkg::POS_W'(p);
      end
    end
  end

  // Held key falls before any press ahead of it replaces it
  assign rel = held_valid_r && fall_mask[held_pos_r] && present_mask[held_pos_r] &&
               ((press_m & below_m) == '0);

  always_comb begin
    held_valid_b  = held_valid_r & ~rel;
    held_pos_b    = held_pos_r;
    press_time_b  = press_time_r;
    long_sent_b   = long_sent_r;
    repeat_sent_b = repeat_sent_r;
    if (any_press) begin
      held_valid_b  = 1'b1;
      held_pos_b    = hi_pos;
      press_time_b  = now_ms;
      long_sent_b   = 1'b0;
      repeat_sent_b = 1'b0;
    end
  end

  assign held_dur    = now_ms - press_time_b;
  assign long_fire   = held_valid_b && !long_sent_b &&
                       (held_dur >= kes_pkg::TIME_W'(long_hold_ms));
  assign long_sent_c = long_sent_b | long_fire;
  assign stamp_c     = long_fire ? now_ms : last_repeat_r;
  assign delay       = repeat_sent_b ? repeat_period_ms : first_repeat_ms;
  assign since_rep   = now_ms - stamp_c;
  assign rep_fire    = held_valid_b && long_sent_c &&
                       (since_rep >= kes_pkg::TIME_W'(delay));

  always_comb begin
    plan             = '0;
    plan.short_ev    = rel & ~long_sent_r;
    plan.release_ev  = rel;
    plan.release_pos = held_pos_r;
    plan.release_dur = now_ms - press_time_r;
    plan.press_mask  = press_m;
    plan.long_ev     = long_fire;
    plan.repeat_ev   = rep_fire;
    plan.held_pos    = held_pos_b;
    plan.held_dur    = held_dur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r  <= 1'b0;
      held_pos_r    <= '0;
      press_time_r  <= '0;
      long_sent_r   <= 1'b0;
      repeat_sent_r <= 1'b0;
      last_repeat_r <= '0;
    end else if (fire) begin
      held_valid_r  <= held_valid_b;
      held_pos_r    <= held_pos_b;
      press_time_r  <= press_time_b;
      long_sent_r   <= long_sent_c;
      repeat_sent_r <= repeat_sent_b | rep_fire;
      last_repeat_r <= rep_fire ? now_ms : stamp_c;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/kes_emit.sv
// ----------------------------------------------------------------------------
// kes_emit
// Event serializer: walks the plan of one scan into the output register, one
// event per cycle unless the output stalls; caps the scan at the result limit.
// ----------------------------------------------------------------------------
`default_nettype none

module kes_emit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            load,
  input  wire kes_pkg::kes_plan_t              plan,
  input  wire logic [kes_pkg::TIME_W-1:0]      now_ms,
  input  wire logic [kes_pkg::POS_COUNT-1:0]   deb_keys,
  output logic                                 can_load,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [2:0]                           out_event_kind,
  output logic [kes_pkg::POS_W-1:0]            out_key_position,
  output logic [kes_pkg::TIME_W-1:0]           out_duration_ms,
  output logic [kes_pkg::TIME_W-1:0]           out_stamp_ms,
  output logic [kes_pkg::POS_COUNT-1:0]        out_debounced_keys,
  output logic                                 out_last_event
);

  // Pending events (control) and scan payload
  logic                           short_r, rel_r, long_r, rep_r;
  logic [kes_pkg::POS_COUNT-1:0]  press_r;
  logic [kes_pkg::EVCNT_W-1:0]    cnt_r;
  logic [kes_pkg::POS_W-1:0]      rel_pos_r, held_pos_r;
  logic [kes_pkg::TIME_W-1:0]     rel_dur_r, held_dur_r, now_r;
  logic [kes_pkg::POS_COUNT-1:0]  deb_r;

  logic                           out_valid_r;
  kes_pkg::event_kind_t           kind_r;
  logic [kes_pkg::POS_W-1:0]      pos_r;
  logic [kes_pkg::TIME_W-1:0]     dur_r, stamp_r;
  logic [kes_pkg::POS_COUNT-1:0]  okeys_r;
  logic                           last_r;

  kes_pkg::event_kind_t           sel_kind;
  logic [kes_pkg::POS_W-1:0]      sel_pos;
  logic [kes_pkg::TIME_W-1:0]     sel_dur;
  logic [kes_pkg::POS_W-1:0]      low_pos;
  logic                           rest_short, rest_rel, rest_long, rest_rep;
  logic [kes_pkg::POS_COUNT-1:0]  rest_press;
  logic                           busy, issue, last;

  always_comb begin
    low_pos = '0;
    for (int p = kes_pkg::POS_COUNT - 1; p >= 0; p--) begin
      if (press_r[p]) begin
        low_pos = kes_pkg::POS_W'(p);
      end
    end
  end

  always_comb begin
    sel_kind   = kes_pkg::EV_REPEAT;
    sel_pos    = held_pos_r;
    sel_dur    = held_dur_r;
    rest_short = short_r;
    rest_rel   = rel_r;
    rest_press = press_r;
    rest_long  = long_r;
    rest_rep   = rep_r;
    if (short_r) begin
      sel_kind   = kes_pkg::EV_SHORT;
      sel_pos    = rel_pos_r;
      sel_dur    = rel_dur_r;
      rest_short = 1'b0;
    end else if (rel_r) begin
      sel_kind   = kes_pkg::EV_RELEASE;
      sel_pos    = rel_pos_r;
      sel_dur    = rel_dur_r;
      rest_rel   = 1'b0;
    end else if (|press_r) begin
      sel_kind   = kes_pkg::EV_PRESS;
      sel_pos    = low_pos;
      sel_dur    = '0;
      rest_press = press_r & (press_r - kes_pkg::POS_COUNT'(1));
    end else if (long_r) begin
      sel_kind   = kes_pkg::EV_LONG;
      rest_long  = 1'b0;
    end else begin
      rest_rep   = 1'b0;
    end
  end

  assign busy  = short_r | rel_r | (|press_r) | long_r | rep_r;
  assign issue = busy && (!out_valid_r || out_ready);
  assign last  = !(rest_short | rest_rel | (|rest_press) | rest_long | rest_rep) ||
                 (cnt_r == kes_pkg::EVCNT_W'(kes_pkg::MAX_RESULTS - 1));
  assign can_load = !busy || (issue && last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_r <= 1'b0;
      rel_r   <= 1'b0;
      press_r <= '0;
      long_r  <= 1'b0;
      rep_r   <= 1'b0;
      cnt_r   <= '0;
    end else if (load) begin
      short_r <= plan.short_ev;
      rel_r   <= plan.release_ev;
      press_r <= plan.press_mask;
      long_r  <= plan.long_ev;
      rep_r   <= plan.repeat_ev;
      cnt_r   <= '0;
    end else if (issue) begin
      // drop whatever is left once the scan hits its result limit
      short_r <= rest_short & ~last;
      rel_r   <= rest_rel & ~last;
      press_r <= last ? '0 : rest_press;
      long_r  <= rest_long & ~last;
      rep_r   <= rest_rep & ~last;
      cnt_r   <= cnt_r + kes_pkg::EVCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rel_pos_r  <= plan.release_pos;
      rel_dur_r  <= plan.release_dur;
      held_pos_r <= plan.held_pos;
      held_dur_r <= plan.held_dur;
      now_r      <= now_ms;
      deb_r      <= deb_keys;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (issue) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      kind_r  <= sel_kind;
      pos_r   <= sel_pos;
      dur_r   <= sel_dur;
      stamp_r <= now_r;
      okeys_r <= deb_r;
      last_r  <= last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_kind     = kind_r;
  assign out_key_position   = pos_r;
  assign out_duration_ms    = dur_r;
  assign out_stamp_ms       = stamp_r;
  assign out_debounced_keys = okeys_r;
  assign out_last_event     = last_r;

endmodule

`default_nettype wire

>>> rtl/core/matrix_keypad_event_scanner.sv
// ----------------------------------------------------------------------------
// matrix_keypad_event_scanner
// Debounced 4x5 key matrix scanner emitting press, short, long, repeat and
// release events per scan.
// ----------------------------------------------------------------------------
// One scan transaction is accepted per cycle as long as the event stage keeps
// up. Twenty debounce lanes update in the accept cycle and their edges are
// registered in the edge stage; the merge stage resolves the held key and the
// long/repeat timing from that register once the serializer can load, and the
// event serializer then drives one event per cycle into the output register
// while out_ready stays high. A scan yields at most 21 events; the serializer
// port is what sets the sustained rate, and the next scan can wait in the edge
// stage while the serializer is still working on the current one.
`default_nettype none

module matrix_keypad_event_scanner (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [1:0]                      cfg_index,
  input  wire logic [kes_pkg::POS_COUNT-1:0]   cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [kes_pkg::POS_COUNT-1:0]   in_raw_keys,
  input  wire logic [kes_pkg::TIME_W-1:0]      in_now_ms,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [2:0]                           out_event_kind,
  output logic [kes_pkg::POS_W-1:0]            out_key_position,
  output logic [kes_pkg::TIME_W-1:0]           out_duration_ms,
  output logic [kes_pkg::TIME_W-1:0]           out_stamp_ms,
  output logic [kes_pkg::POS_COUNT-1:0]        out_debounced_keys,
  output logic                                 out_last_event
);

  logic [kes_pkg::MS_W-1:0]       long_press_r;
  logic [kes_pkg::MS_W-1:0]       repeat_initial_r;
  logic [kes_pkg::MS_W-1:0]       repeat_period_r;
  logic [kes_pkg::POS_COUNT-1:0]  key_mask_r;

  logic                           in_accept;
  logic [kes_pkg::POS_COUNT-1:0]  lane_pressed, lane_rise, lane_fall;

  logic                           edge_v_r;
  logic [kes_pkg::POS_COUNT-1:0]  rise_r, fall_r, deb_r;
  logic [kes_pkg::TIME_W-1:0]     now_r;

  logic                           can_load;
  logic                           merge_fire;
  kes_pkg::kes_plan_t             plan;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r     <= kes_pkg::LONG_PRESS_RESET;
      repeat_initial_r <= kes_pkg::REPEAT_INITIAL_RESET;
      repeat_period_r  <= kes_pkg::REPEAT_PERIOD_RESET;
      key_mask_r       <= kes_pkg::KEY_MASK_RESET;
    end else if (cfg_we) begin
      unique case (kes_pkg::cfg_reg_t'(cfg_index))
        kes_pkg::REG_LONG_PRESS:     long_press_r     <= cfg_wdata[kes_pkg::MS_W-1:0];
        kes_pkg::REG_REPEAT_INITIAL: repeat_initial_r <= cfg_wdata[kes_pkg::MS_W-1:0];
        kes_pkg::REG_REPEAT_PERIOD:  repeat_period_r  <= cfg_wdata[kes_pkg::MS_W-1:0];
        kes_pkg::REG_KEY_MASK:       key_mask_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign merge_fire = edge_v_r && can_load;
  assign in_ready   = !edge_v_r || merge_fire;
  assign in_accept  = in_valid && in_ready;

  for (genvar g = 0; g < kes_pkg::POS_COUNT; g++) begin : g_lane
    kes_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .scan_en (in_accept),
      .sample  (in_raw_keys[g]),
      .pressed (lane_pressed[g]),
      .rise    (lane_rise[g]),
      .fall    (lane_fall[g])
    );
  end

  // Edge stage: hold the lanes' findings until the merge stage takes them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_v_r <= 1'b0;
    end else if (in_accept) begin
      edge_v_r <= 1'b1;
    end else if (merge_fire) begin
      edge_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rise_r <= lane_rise;
      fall_r <= lane_fall;
      deb_r  <= lane_pressed;
      now_r  <= in_now_ms;
    end
  end

  kes_merge u_merge (
    .clk               (clk),
    .rst_n             (rst_n),
    .fire              (merge_fire),
    .rise_mask         (rise_r),
    .fall_mask         (fall_r),
    .present_mask      (key_mask_r),
    .now_ms            (now_r),
    .long_hold_ms      (long_press_r),
    .first_repeat_ms   (repeat_initial_r),
    .repeat_period_ms  (repeat_period_r),
    .plan              (plan)
  );

  kes_emit u_emit (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (merge_fire),
    .plan               (plan),
    .now_ms             (now_r),
    .deb_keys           (deb_r),
    .can_load           (can_load),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_kind     (out_event_kind),
    .out_key_position   (out_key_position),
    .out_duration_ms    (out_duration_ms),
    .out_stamp_ms       (out_stamp_ms),
    .out_debounced_keys (out_debounced_keys),
    .out_last_event     (out_last_event)
  );

  a_edge_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> edge_v_r)
    else $error("accepted scan not held in edge stage");

  a_press_zero_dur: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind == kes_pkg::EV_PRESS) |-> (out_duration_ms == '0))
    else $error("press event with nonzero duration");

  a_short_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind == kes_pkg::EV_SHORT) |-> !out_last_event)
    else $error("short event not followed by release");

  a_press_debounced: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind == kes_pkg::EV_PRESS) |->
      out_debounced_keys[out_key_position])
    else $error("press event on a key that is not debounced as pressed");

endmodule

`default_nettype wire

>>> sim/matrix_keypad_event_scanner_tb.sv
// ----------------------------------------------------------------------------
// matrix_keypad_event_scanner_tb
// Self-checking bench for the keypad event scanner. Scan transactions go in
// through a valid/ready port and feed a local model of the debounce lanes,
// the held-key tracking and the long/repeat timers. Every emitted event is
// checked field by field against that model, in order. Directed scans cover
// wrap-around time, unpopulated keys, key handover, mask changes under a held
// key, zero and maximum timing and the 21-event cap, then random gestures and
// noise run under several register settings, mostly with random stalls on both sides.
// ----------------------------------------------------------------------------
module matrix_keypad_event_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES  = 400_000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    kes_pkg::event_kind_t          kind;
    logic [kes_pkg::POS_W-1:0]     pos;
    logic [kes_pkg::TIME_W-1:0]    dur;
    logic [kes_pkg::TIME_W-1:0]    stamp;
    logic [kes_pkg::POS_COUNT-1:0] keys;
    logic                          last;
  } key_event_t;

  logic                          clk                = 1'b0;
  logic                          rst_n              = 1'b0;
  logic                          cfg_we             = 1'b0;
  logic [1:0]                    cfg_index          = kes_pkg::REG_LONG_PRESS;
  logic [kes_pkg::POS_COUNT-1:0] cfg_wdata          = '0;
  logic                          in_valid           = 1'b0;
  logic                          in_ready;
  logic [kes_pkg::POS_COUNT-1:0] in_raw_keys        = '0;
  logic [kes_pkg::TIME_W-1:0]    in_now_ms          = '0;
  logic                          out_valid;
  logic                          out_ready          = 1'b0;
  logic [2:0]                    out_event_kind;
  logic [kes_pkg::POS_W-1:0]     out_key_position;
  logic [kes_pkg::TIME_W-1:0]    out_duration_ms;
  logic [kes_pkg::TIME_W-1:0]    out_stamp_ms;
  logic [kes_pkg::POS_COUNT-1:0] out_debounced_keys;
  logic                          out_last_event;

  // Local copy of the block's registers and key state
  logic [kes_pkg::MS_W-1:0]      long_press_limit = kes_pkg::LONG_PRESS_RESET;
  logic [kes_pkg::MS_W-1:0]      repeat_first_gap = kes_pkg::REPEAT_INITIAL_RESET;
  logic [kes_pkg::MS_W-1:0]      repeat_gap       = kes_pkg::REPEAT_PERIOD_RESET;
  logic [kes_pkg::POS_COUNT-1:0] populated_mask   = kes_pkg::KEY_MASK_RESET;
  logic [kes_pkg::CNT_W-1:0]     db_count [kes_pkg::POS_COUNT] = '{default: '0};
  logic [kes_pkg::POS_COUNT-1:0] db_keys      = '0;
  logic                          held_on      = 1'b0;
  logic [kes_pkg::POS_W-1:0]     held_key     = '0;
  logic [kes_pkg::TIME_W-1:0]    press_stamp  = '0;
  logic                          long_done    = 1'b0;
  logic                          repeat_done  = 1'b0;
  logic [kes_pkg::TIME_W-1:0]    repeat_stamp = '0;

  key_event_t  scan_events[$];
  key_event_t  expected_events[$];
  int          err_count      = 0;
  int          scans_sent     = 0;
  int          cycle_count    = 0;
  logic [31:0] scan_clock_ms  = '0;
  bit          tx_steady      = 1'b0;
  bit          rx_steady      = 1'b0;
  int unsigned rx_holdoff_req = 0;
  int unsigned rx_hold_left   = 0;

  matrix_keypad_event_scanner u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_raw_keys        (in_raw_keys),
    .in_now_ms          (in_now_ms),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_kind     (out_event_kind),
    .out_key_position   (out_key_position),
    .out_duration_ms    (out_duration_ms),
    .out_stamp_ms       (out_stamp_ms),
    .out_debounced_keys (out_debounced_keys),
    .out_last_event     (out_last_event)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Event prediction
  // --------------------------------------------------------------------------
  function void add_event(kes_pkg::event_kind_t kind, logic [kes_pkg::POS_W-1:0] pos,
                          logic [kes_pkg::TIME_W-1:0] dur);
    key_event_t ev;
    // Drop anything past the per-scan cap; state still moves on
    if (scan_events.size() < kes_pkg::MAX_RESULTS) begin
      ev.kind  = kind;
      ev.pos   = pos;
      ev.dur   = dur;
      ev.stamp = '0;
      ev.keys  = '0;
      ev.last  = 1'b0;
      scan_events.push_back(ev);
    end
  endfunction

  task predict_scan(input logic [kes_pkg::POS_COUNT-1:0] raw,
                    input logic [kes_pkg::TIME_W-1:0] now);
    logic                       was_down;
    logic                       is_down;
    logic [kes_pkg::TIME_W-1:0] held_ms;
    logic [kes_pkg::TIME_W-1:0] since_repeat;
    logic [kes_pkg::TIME_W-1:0] gap_ms;
    key_event_t                 ev;
    scan_events.delete();
    for (int p = 0; p < kes_pkg::POS_COUNT; p++) begin
      was_down = db_keys[p];
      if (raw[p]) begin
        if (db_count[p] < kes_pkg::DEBOUNCE_LEVEL) db_count[p] = db_count[p] + 1'b1;
      end else if (db_count[p] != 0) begin
        db_count[p] = db_count[p] - 1'b1;
      end
      is_down    = (db_count[p] >= kes_pkg::DEBOUNCE_LEVEL);
      db_keys[p] = is_down;
      if (is_down && !was_down) begin
        if (populated_mask[p]) begin
          held_on     = 1'b1;
          held_key    = kes_pkg::POS_W'(p);
          press_stamp = now;
          long_done   = 1'b0;
          repeat_done = 1'b0;
          add_event(kes_pkg::EV_PRESS, kes_pkg::POS_W'(p), '0);
        end
      end else if (!is_down && was_down && populated_mask[p] && held_on &&
                   held_key == p) begin
        held_ms = now - press_stamp;
        if (!long_done) add_event(kes_pkg::EV_SHORT, kes_pkg::POS_W'(p), held_ms);
        add_event(kes_pkg::EV_RELEASE, kes_pkg::POS_W'(p), held_ms);
        held_on = 1'b0;
      end
    end
    if (held_on) begin
      held_ms = now - press_stamp;
      if (!long_done && held_ms >= {16'h0, long_press_limit}) begin
        add_event(kes_pkg::EV_LONG, held_key, held_ms);
        long_done    = 1'b1;
        repeat_stamp = now;
      end
      if (long_done) begin
        gap_ms       = {16'h0, (repeat_done ? repeat_gap : repeat_first_gap)};
        since_repeat = now - repeat_stamp;
        if (since_repeat >= gap_ms) begin
          add_event(kes_pkg::EV_REPEAT, held_key, held_ms);
          repeat_stamp = now;
          repeat_done  = 1'b1;
        end
      end
    end
    for (int k = 0; k < scan_events.size(); k++) begin
      ev       = scan_events[k];
      ev.stamp = now;
      ev.keys  = db_keys;
      ev.last  = (k == scan_events.size() - 1);
      expected_events.push_back(ev);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) predict_scan(in_raw_keys, in_now_ms);
  end

  // --------------------------------------------------------------------------
  // Event checking
  // --------------------------------------------------------------------------
  task report_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    key_event_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected event, expected none, actual kind %0d key %0d stamp %0h",
                 $time, out_event_kind, out_key_position, out_stamp_ms);
        err_count++;
      end else begin
        want = expected_events.pop_front();
        report_field("event_kind", want.kind, out_event_kind);
        report_field("key_position", want.pos, out_key_position);
        report_field("duration_ms", want.dur, out_duration_ms);
        report_field("stamp_ms", want.stamp, out_stamp_ms);
        report_field("debounced_keys", want.keys, out_debounced_keys);
        report_field("last_event", want.last, out_last_event);
      end
    end
  end

  // Receiver: random stalls, steady stretches and requested long hold-offs
  initial begin
    forever begin
      @(posedge clk);
      if (rx_holdoff_req != 0) begin
        rx_hold_left   = rx_holdoff_req;
        rx_holdoff_req = 0;
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        out_ready <= 1'b0;
      end else if (rx_steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 34);
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("matrix_keypad_event_scanner verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------
  // Advance the scan clock by step_ms and offer one scan; returns on acceptance
  // with valid still high so the next scan can follow without a bubble.
  task send_scan(input logic [kes_pkg::POS_COUNT-1:0] raw, input logic [31:0] step_ms);
    if (!tx_steady && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 34);
    end
    scan_clock_ms = scan_clock_ms + step_ms;
    in_valid    <= 1'b1;
    in_raw_keys <= raw;
    in_now_ms   <= scan_clock_ms;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    scans_sent++;
  endtask

  // Hold the sender until every expected event is out, then let the block settle
  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_reg(input kes_pkg::cfg_reg_t idx, input logic [kes_pkg::POS_COUNT-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      kes_pkg::REG_LONG_PRESS:     long_press_limit = value[kes_pkg::MS_W-1:0];
      kes_pkg::REG_REPEAT_INITIAL: repeat_first_gap = value[kes_pkg::MS_W-1:0];
      kes_pkg::REG_REPEAT_PERIOD:  repeat_gap       = value[kes_pkg::MS_W-1:0];
      kes_pkg::REG_KEY_MASK:       populated_mask   = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task write_timing(input logic [kes_pkg::MS_W-1:0] long_ms,
                    input logic [kes_pkg::MS_W-1:0] first_ms,
                    input logic [kes_pkg::MS_W-1:0] period_ms);
    write_reg(kes_pkg::REG_LONG_PRESS, kes_pkg::POS_COUNT'(long_ms));
    write_reg(kes_pkg::REG_REPEAT_INITIAL, kes_pkg::POS_COUNT'(first_ms));
    write_reg(kes_pkg::REG_REPEAT_PERIOD, kes_pkg::POS_COUNT'(period_ms));
  endtask

  function logic [31:0] next_step();
    // Mostly short scan intervals, now and then a jump across the time wrap
    if ($urandom_range(99) < 4) return $urandom();
    return $urandom_range(1, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task test_press_and_release();
    // Populated key 0 and unpopulated key 4 together, across the time wrap
    scan_clock_ms = 32'hFFFF_FFE0;
    send_scan('0, 0);
    repeat (3) send_scan(20'h00011, 10);
    send_scan('0, 10);
    drain();
  endtask

  task test_long_and_repeat();
    repeat (3) send_scan(20'h00080, 10);
    send_scan(20'h00080, 999);
    send_scan(20'h00080, 1);
    send_scan(20'h00080, 500);
    send_scan(20'h00080, 99);
    send_scan(20'h00080, 1);
    send_scan('0, 10);
    drain();
  endtask

  task test_key_handover();
    // Key 3 takes over from key 2; the release of key 2 stays silent
    repeat (3) send_scan(20'h00004, 10);
    repeat (3) send_scan(20'h0000C, 10);
    send_scan(20'h00008, 10);
    send_scan('0, 10);
    drain();
  endtask

  task test_mask_under_hold();
    repeat (3) send_scan(20'h00020, 10);
    drain();
    write_reg(kes_pkg::REG_KEY_MASK, kes_pkg::KEY_MASK_RESET & ~20'h00020);
    send_scan('0, 10);
    repeat (3) send_scan(20'h00040, 10);
    send_scan('0, 10);
    drain();
    // Nothing mapped: keys debounce but stay silent
    write_reg(kes_pkg::REG_KEY_MASK, '0);
    repeat (3) send_scan(20'h00002, 10);
    send_scan('0, 10);
    drain();
    write_reg(kes_pkg::REG_KEY_MASK, kes_pkg::KEY_MASK_RESET);
  endtask

  task test_max_timing();
    write_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (3) send_scan(20'h00100, 10);
    send_scan(20'h00100, 65534);
    send_scan(20'h00100, 1);
    send_scan(20'h00100, 65534);
    send_scan(20'h00100, 1);
    send_scan(20'h00100, 65535);
    send_scan('0, 10);
    drain();
  endtask

  task test_zero_timing_overflow();
    write_timing('0, '0, '0);
    write_reg(kes_pkg::REG_KEY_MASK, 20'hFFFFF);
    repeat (3) send_scan(20'h00001, 10);
    send_scan(20'h00001, 10);
    repeat (2) send_scan(20'hFFFFF, 10);
    // Release of key 0 plus nineteen presses and a long fill the cap
    send_scan(20'hFFFFE, 10);
    send_scan(20'hFFFFE, 10);
    drain();
  endtask

  task test_stalled_receiver();
    // Hold the receiver off while the sender keeps pushing repeat-heavy scans
    tx_steady      = 1'b1;
    rx_holdoff_req = 400;
    repeat (20) send_scan(20'hFFFFE, 10);
    repeat (3) send_scan('0, 10);
    repeat (3) send_scan(20'hFFFFF, 10);
    repeat (3) send_scan('0, 10);
    drain();
    tx_steady = 1'b0;
  endtask

  task run_gestures(input int count);
    int                            target;
    int                            hold;
    logic [kes_pkg::POS_COUNT-1:0] keys;
    logic [kes_pkg::POS_COUNT-1:0] raw;
    target = scans_sent + count;
    while (scans_sent < target) begin
      if ($urandom_range(99) < 80) begin
        keys = kes_pkg::POS_COUNT'(1) << $urandom_range(kes_pkg::POS_COUNT - 1);
        if ($urandom_range(3) == 0) begin
          keys |= kes_pkg::POS_COUNT'(1) << $urandom_range(kes_pkg::POS_COUNT - 1);
        end
        hold = $urandom_range(3, 14);
        repeat (hold) begin
          raw = keys;
          if ($urandom_range(9) == 0) begin
            raw ^= kes_pkg::POS_COUNT'(1) << $urandom_range(kes_pkg::POS_COUNT - 1);
          end
          send_scan(raw, next_step());
        end
        repeat ($urandom_range(1, 3)) send_scan('0, next_step());
      end else begin
        repeat ($urandom_range(1, 3)) send_scan(kes_pkg::POS_COUNT'($urandom()), next_step());
      end
    end
  endtask

  task test_random_traffic();
    logic [kes_pkg::POS_COUNT-1:0] mask;
    // No idling on either side for the first stretch
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    write_timing(16'd60, 16'd40, 16'd20);
    write_reg(kes_pkg::REG_KEY_MASK, kes_pkg::KEY_MASK_RESET);
    run_gestures(14);
    drain();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    repeat (3) begin
      write_timing(kes_pkg::MS_W'($urandom_range(0, 250)),
                   kes_pkg::MS_W'($urandom_range(0, 150)),
                   kes_pkg::MS_W'($urandom_range(0, 80)));
      mask = ($urandom_range(2) == 0) ? 20'hFFFFF : kes_pkg::POS_COUNT'($urandom());
      write_reg(kes_pkg::REG_KEY_MASK, mask);
      run_gestures(8);
      drain();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_press_and_release();
    test_long_and_repeat();
    test_key_handover();
    test_mask_under_hold();
    test_max_timing();
    test_zero_timing_overflow();
    test_stalled_receiver();
    test_random_traffic();
    drain();
    if (err_count == 0 && expected_events.size() == 0) begin
      $display("matrix_keypad_event_scanner verification clean");
    end else begin
      $display("matrix_keypad_event_scanner verification failed");
    end
    $finish;
  end

endmodule
